FILE: src/ssv_pkg.sv
`default_nettype none
package ssv_pkg;

    // Outcome of one read attempt, carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_SETUP   = 2'd0,
        FUNC_TRIGGER = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_OK      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_TRIGGER = 2'd1,
        CAUSE_READ    = 2'd2
    } cause_t;

    typedef enum logic [1:0] {
        REG_BASE_INTERVAL = 2'd0,
        REG_CAL_OFFSET    = 2'd1,
        REG_ALERT_THRESH  = 2'd2,
        REG_BACKOFF_MAX   = 2'd3
    } reg_idx_t;

    localparam logic [15:0]        BASE_INTERVAL_RST = 16'd2000;
    localparam logic signed [10:0] CAL_OFFSET_RST    = 11'sd0;
    localparam logic [7:0]         ALERT_THRESH_RST  = 8'd5;
    localparam logic [15:0]        BACKOFF_MAX_RST   = 16'd60000;

    // Readings in this window are the sensor's power-on value
    localparam logic signed [14:0] POWERON_LO = 15'sd8490;
    localparam logic signed [14:0] POWERON_HI = 15'sd8510;

    localparam logic [7:0] FAIL_COUNT_MAX = 8'd255;
    localparam int         AVG_POS_LIMIT  = 16383;
    localparam int         AVG_NEG_LIMIT  = 16384;

    typedef struct packed {
        logic load;
        logic store;
        logic acc_step;
        logic div_start;
        logic commit;
    } ssv_cmd_t;

    typedef struct packed {
        logic good;
        logic sum_last;
        logic div_done;
    } ssv_stat_t;

    typedef struct packed {
        logic [1:0]         samples_in_average;
        logic               rebuild_bus;
        cause_t             alert_cause;
        logic               alert_raised;
        logic [15:0]        wait_ms;
        logic               reading_valid;
        logic signed [14:0] avg_temp_centi;
    } ssv_res_t;

endpackage
`default_nettype wire

FILE: src/sensor_read_supervisor.sv
// Temperature read supervisor. Each input transaction carries the outcome of one read
// attempt (s_tuser) and the raw reading in hundredths of a degree (s_tdata), and yields
// exactly one output transaction with the held moving average, a valid flag, the wait
// before the next attempt, alert and rebuild flags and the window fill. One item is in
// work at a time: a failure or a power-on reading goes from decode straight to the finish
// step, while a good reading is stored in the ring, summed by the one-sample-per-cycle
// ring sum and divided by the one-bit-per-cycle divider that forms the mean. The next
// item is taken in the cycle after the commit, also while a result waits in the output
// register; an item whose result cannot leave holds in its last step until the output
// register frees up.
// Registers sit on the APB port at byte addresses 0x0 (base interval), 0x4 (calibration
// offset), 0x8 (alert threshold) and 0xC (backoff cap); write them only while the block
// is idle.
`default_nettype none
module sensor_read_supervisor #(
    parameter int AVG_WINDOW = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [14:0] temp_centi
    input  wire logic [1:0]  s_tuser,   // [1:0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [14:0] avg_temp_centi, [30:15] wait_ms, [31] alert_raised, [33:32] alert_cause,
    // [34] rebuild_bus, [36:35] samples_in_average
    output logic [39:0]      m_tdata,
    output logic             m_tuser,   // [0] reading_valid
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ssv_pkg::*;

    logic [15:0]        base_reg;
    logic signed [10:0] offset_reg;
    logic [7:0]         thresh_reg;
    logic [15:0]        bmax_reg;

    ssv_cmd_t  cmd;
    ssv_stat_t stat;
    ssv_res_t  res;
    ssv_res_t  out_reg;
    logic      out_valid_reg, out_valid_next;
    logic      out_free;
    logic      cfg_wr;
    reg_idx_t  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_INTERVAL_RST;
            offset_reg <= CAL_OFFSET_RST;
            thresh_reg <= ALERT_THRESH_RST;
            bmax_reg   <= BACKOFF_MAX_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_BASE_INTERVAL: base_reg   <= pwdata[15:0];
                REG_CAL_OFFSET:    offset_reg <= pwdata[10:0];
                REG_ALERT_THRESH:  thresh_reg <= pwdata[7:0];
                REG_BACKOFF_MAX:   bmax_reg   <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_BASE_INTERVAL: prdata = {16'd0, base_reg};
            REG_CAL_OFFSET:    prdata = 32'(offset_reg);
            REG_ALERT_THRESH:  prdata = {24'd0, thresh_reg};
            REG_BACKOFF_MAX:   prdata = {16'd0, bmax_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign out_free = !out_valid_reg || m_tready;

    ssv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssv_dp #(
        .AVG_WINDOW(AVG_WINDOW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_func       (s_tuser),
        .in_temp       ($signed(s_tdata[14:0])),
        .base_interval (base_reg),
        .cal_offset    (offset_reg),
        .alert_thresh  (thresh_reg),
        .backoff_max   (bmax_reg),
        .res           (res)
    );

    assign out_valid_next = cmd.commit || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.reading_valid;
    assign m_tdata  = {3'd0, out_reg.samples_in_average, out_reg.rebuild_bus,
                       out_reg.alert_cause, out_reg.alert_raised, out_reg.wait_ms,
                       out_reg.avg_temp_centi};

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again while an item is in work");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result committed over a pending output transaction");

    a_alert_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[31]) |-> (m_tdata[34] && cause_t'(m_tdata[33:32]) != CAUSE_NONE))
        else $error("alert without failure cause");

    a_valid_not_on_failure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser && m_tdata[34]))
        else $error("valid reading reported on a failed attempt");

endmodule
`default_nettype wire

FILE: src/ssv_div.sv
`default_nettype none
module ssv_div #(
    parameter int N_W = 18,
    parameter int D_W = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic                done,
    output logic [N_W-1:0]      quotient
);
    localparam int STEP_W = $clog2(N_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [N_W-1:0]    quo_reg, quo_next;
    logic [D_W-1:0]    rem_reg, rem_next;
    logic [D_W:0]      shifted;
    logic [D_W:0]      diff;

    // One restoring step per cycle, most significant dividend bit first
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[N_W-1]};
        diff      = shifted - {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(N_W);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = diff[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: src/ssv_dp.sv
`default_nettype none
module ssv_dp #(
    parameter int AVG_WINDOW = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ssv_pkg::ssv_cmd_t  cmd,
    output ssv_pkg::ssv_stat_t      stat,
    input  wire logic [1:0]         in_func,
    input  wire logic signed [14:0] in_temp,
    input  wire logic [15:0]        base_interval,
    input  wire logic signed [10:0] cal_offset,
    input  wire logic [7:0]         alert_thresh,
    input  wire logic [15:0]        backoff_max,
    output ssv_pkg::ssv_res_t       res
);
    import ssv_pkg::*;

    localparam int SLOT_W = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int CNT_W  = $clog2(AVG_WINDOW + 1);
    localparam int SUM_W  = 16 + $clog2(AVG_WINDOW);

    func_t                    func_reg;
    logic signed [14:0]       temp_reg;
    logic signed [15:0]       ring_reg [AVG_WINDOW];
    logic [SLOT_W-1:0]        slot_reg;
    logic [SLOT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic [7:0]               fail_reg, fail_next;
    logic                     latched_reg, latched_next;
    logic [15:0]              backoff_reg, backoff_next;
    logic                     valid_reg, valid_next;
    logic signed [14:0]       held_reg, held_next;

    logic signed [15:0]       sample_val;
    logic                     in_window;
    logic [SUM_W-1:0]         acc_mag;
    logic [SUM_W-1:0]         quotient;
    logic [SUM_W-1:0]         quo_neg;
    logic signed [14:0]       avg_sat;
    logic [7:0]               fail_inc;
    logic [16:0]              doubled;
    logic [15:0]              backoff_adv;

    assign sample_val = 16'(temp_reg) + 16'(cal_offset);
    assign in_window  = (temp_reg >= POWERON_LO) && (temp_reg <= POWERON_HI);
    assign acc_mag    = acc_reg[SUM_W-1] ? (SUM_W'(0) - SUM_W'(acc_reg)) : SUM_W'(acc_reg);

    assign stat.good     = (func_reg == FUNC_OK) && !in_window;
    assign stat.sum_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    ssv_div #(
        .N_W(SUM_W),
        .D_W(CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_mag),
        .divisor  (count_reg),
        .done     (stat.div_done),
        .quotient (quotient)
    );

    // Restore the sign of the magnitude quotient and clamp to the 15-bit field
    always_comb
    begin
        quo_neg = SUM_W'(0) - quotient;
        if (!acc_reg[SUM_W-1])
            avg_sat = (quotient > SUM_W'(AVG_POS_LIMIT)) ? 15'sd16383 : quotient[14:0];
        else
            avg_sat = (quotient > SUM_W'(AVG_NEG_LIMIT)) ? -15'sd16384 : quo_neg[14:0];
    end

    always_comb
    begin
        fail_inc = (fail_reg == FAIL_COUNT_MAX) ? fail_reg : fail_reg + 8'd1;
        doubled  = {backoff_reg, 1'b0};
        if (backoff_reg < backoff_max)
            backoff_adv = (doubled < {1'b0, backoff_max}) ? doubled[15:0] : backoff_max;
        else
            backoff_adv = backoff_reg;

        fail_next        = fail_reg;
        latched_next     = latched_reg;
        backoff_next     = backoff_reg;
        valid_next       = valid_reg;
        held_next        = held_reg;
        res.wait_ms      = base_interval;
        res.alert_raised = 1'b0;
        res.alert_cause  = CAUSE_NONE;
        res.rebuild_bus  = 1'b0;

        case (func_reg)
            FUNC_OK:
            begin
                if (!in_window)
                begin
                    held_next    = avg_sat;
                    valid_next   = 1'b1;
                    fail_next    = 8'd0;
                    latched_next = 1'b0;
                    backoff_next = base_interval;
                end
            end
            FUNC_READ:
            begin
                valid_next      = 1'b0;
                res.rebuild_bus = 1'b1;
                fail_next       = fail_inc;
                backoff_next    = backoff_adv;
                res.wait_ms     = backoff_adv;
                if (fail_inc >= alert_thresh && !latched_reg)
                begin
                    latched_next     = 1'b1;
                    res.alert_raised = 1'b1;
                    res.alert_cause  = CAUSE_READ;
                end
            end
            FUNC_TRIGGER:
            begin
                valid_next      = 1'b0;
                res.rebuild_bus = 1'b1;
                fail_next       = fail_inc;
                backoff_next    = backoff_adv;
                res.wait_ms     = backoff_reg;
                if (fail_inc >= alert_thresh && !latched_reg)
                begin
                    latched_next     = 1'b1;
                    res.alert_raised = 1'b1;
                    res.alert_cause  = CAUSE_TRIGGER;
                end
            end
            default:
            begin
                // Setup failure: report current backoff, then grow it
                valid_next      = 1'b0;
                res.rebuild_bus = 1'b1;
                backoff_next    = backoff_adv;
                res.wait_ms     = backoff_reg;
            end
        endcase

        res.avg_temp_centi     = held_next;
        res.reading_valid      = valid_next;
        res.samples_in_average = 2'(count_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(in_func);
            temp_reg <= in_temp;
        end
        if (cmd.store)
        begin
            ring_reg[slot_reg] <= sample_val;
            acc_reg            <= '0;
            idx_reg            <= '0;
        end
        else if (cmd.acc_step)
        begin
            acc_reg <= acc_reg + SUM_W'(ring_reg[idx_reg]);
            idx_reg <= idx_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            count_reg   <= '0;
            fail_reg    <= 8'd0;
            latched_reg <= 1'b0;
            backoff_reg <= BASE_INTERVAL_RST;
            valid_reg   <= 1'b0;
            held_reg    <= 15'sd0;
        end
        else
        begin
            if (cmd.store)
            begin
                slot_reg <= (slot_reg == SLOT_W'(AVG_WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
                if (count_reg != CNT_W'(AVG_WINDOW))
                    count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.commit)
            begin
                fail_reg    <= fail_next;
                latched_reg <= latched_next;
                backoff_reg <= backoff_next;
                valid_reg   <= valid_next;
                held_reg    <= held_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/ssv_ctrl.sv
`default_nettype none
module ssv_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               out_free,
    input  wire ssv_pkg::ssv_stat_t stat,
    output ssv_pkg::ssv_cmd_t       cmd
);
    import ssv_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                // Good readings go through the ring; everything else finishes now
                if (stat.good)
                begin
                    cmd.store  = 1'b1;
                    state_next = ST_SUM;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_SUM:
            begin
                cmd.acc_step = 1'b1;
                if (stat.sum_last)
                    state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Hold until the output register can take the result
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire
